// ----- rtl/windowed_kalman_smoother_defines.svh -----
`ifndef WINDOWED_KALMAN_SMOOTHER_DEFINES_SVH
`define WINDOWED_KALMAN_SMOOTHER_DEFINES_SVH

// same-cycle implication
`define WKS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WKS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wks_pkg.sv -----
package wks_pkg;

  localparam int CHANNELS   = 8;
  localparam int WINDOW_MAX = 16;

  localparam int DEPTH     = CHANNELS * WINDOW_MAX;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SLOT_W    = $clog2(WINDOW_MAX);
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int DIV_STEPS = 25;
  localparam int DCNT_W    = $clog2(DIV_STEPS);

  localparam logic [24:0] ONE_Q24  = 25'h100_0000;
  localparam logic [57:0] HALF_Q24 = 58'h80_0000;

  typedef enum logic [1:0] {
    ST_FILTERED = 2'd0,
    ST_BYPASS   = 2'd1,
    ST_PRIMED   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_WIN_LEN  = 3'd0,
    CFG_INIT_COV = 3'd1,
    CFG_PROC_NS  = 3'd2,
    CFG_MEAS_NS  = 3'd3,
    CFG_MIN_THR  = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_BYP,
    S_PRIME,
    S_PRM_DONE,
    S_WRS,
    S_RD,
    S_ADDQ,
    S_DIV,
    S_MULX,
    S_MULP,
    S_UPDP,
    S_FLT_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         channel;
    logic signed [31:0] sample;
  } in_t;

  typedef struct packed {
    logic signed [31:0] estimate;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic    capture;
    logic    prime_wr;
    logic    wr_last;
    logic    rd;
    logic    addq;
    logic    div_step;
    logic    mulx;
    logic    mulp;
    logic    updp;
    logic    inc_i;
    logic    set_primed;
    logic    load_out;
    logic    out_from_x;
    status_e out_code;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic prime;
    logic i_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/wks_ctrl.sv -----
module wks_ctrl import wks_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_DECIDE;
      S_DECIDE: begin
        priority if (sts_i.bypass) state_d = S_BYP;
        else if (sts_i.prime)      state_d = S_PRIME;
        else                       state_d = S_WRS;
      end
      S_BYP:      if (sts_i.out_free) state_d = S_IDLE;
      S_PRIME:    if (sts_i.i_last) state_d = S_PRM_DONE;
      S_PRM_DONE: if (sts_i.out_free) state_d = S_IDLE;
      S_WRS:      state_d = S_RD;
      S_RD:       state_d = S_ADDQ;
      S_ADDQ:     state_d = S_DIV;
      S_DIV:      if (sts_i.div_done) state_d = S_MULX;
      S_MULX:     state_d = S_MULP;
      S_MULP:     state_d = S_UPDP;
      S_UPDP:     state_d = sts_i.i_last ? S_FLT_DONE : S_RD;
      S_FLT_DONE: if (sts_i.out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.out_code = ST_FILTERED;
    in_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_BYP: begin
        cmd_o.load_out = sts_i.out_free;
        cmd_o.out_code = ST_BYPASS;
      end
      S_PRIME: begin
        cmd_o.prime_wr = 1'b1;
        cmd_o.inc_i    = !sts_i.i_last;
      end
      S_PRM_DONE: begin
        cmd_o.load_out   = sts_i.out_free;
        cmd_o.set_primed = sts_i.out_free;
        cmd_o.out_code   = ST_PRIMED;
      end
      S_WRS:  cmd_o.wr_last  = 1'b1;
      S_RD:   cmd_o.rd       = 1'b1;
      S_ADDQ: cmd_o.addq     = 1'b1;
      S_DIV:  cmd_o.div_step = 1'b1;
      S_MULX: cmd_o.mulx     = 1'b1;
      S_MULP: cmd_o.mulp     = 1'b1;
      S_UPDP: begin
        cmd_o.updp  = 1'b1;
        cmd_o.inc_i = !sts_i.i_last;
      end
      S_FLT_DONE: begin
        cmd_o.load_out   = sts_i.out_free;
        cmd_o.out_from_x = 1'b1;
        cmd_o.out_code   = ST_FILTERED;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- rtl/wks_dpath.sv -----
module wks_dpath import wks_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_t         in_data_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o
);

  logic [4:0]  win_len_q;
  logic [31:0] init_cov_q, proc_ns_q, meas_ns_q;
  logic signed [31:0] min_thr_q;

  logic [CHANNELS-1:0] primed_q;
  logic                out_valid_q;

  logic [2:0]         ch_q;
  logic signed [31:0] s_q;
  logic [SLOT_W-1:0]  i_q;
  logic [31:0]        p_q;
  logic [32:0]        den_q;
  logic [32:0]        rem_q;
  logic [24:0]        quo_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic signed [31:0] v_q, x_q;
  logic               neg_q;
  logic [57:0]        prod_q;
  out_t               out_q;
  logic [31:0]        rdata_q;

  logic [31:0] mem [DEPTH];

  // effective window length minus one
  logic [31:0]       len_tmp;
  logic [SLOT_W-1:0] n_m1;
  always_comb begin
    priority if (win_len_q == 5'd0)   len_tmp = 32'd0;
    else if (32'(win_len_q) > WINDOW_MAX) len_tmp = 32'(WINDOW_MAX - 1);
    else                               len_tmp = 32'(win_len_q) - 32'd1;
  end
  assign n_m1 = len_tmp[SLOT_W-1:0];

  logic                in_range;
  logic [CH_IDX_W-1:0] ch_idx;
  assign in_range = 32'(ch_q) < CHANNELS;
  assign ch_idx   = CH_IDX_W'(ch_q);

  logic [31:0] base;
  assign base = 32'(ch_q) * 32'(WINDOW_MAX);

  logic [SLOT_W-1:0] i_m1;
  assign i_m1 = i_q - SLOT_W'(1);

  logic              we;
  logic [SLOT_W-1:0] wslot;
  logic [31:0]       wdata;
  always_comb begin
    we    = 1'b0;
    wslot = i_q;
    wdata = s_q;
    priority if (cmd_i.prime_wr) begin
      we = (i_q != n_m1);
    end else if (cmd_i.wr_last) begin
      we    = 1'b1;
      wslot = n_m1;
    end else if (cmd_i.addq) begin
      we    = (i_q != '0);
      wslot = i_m1;
      wdata = rdata_q;
    end
  end

  logic [ADDR_W-1:0] waddr, raddr;
  assign waddr = ADDR_W'(base + 32'(wslot));
  assign raddr = ADDR_W'(base + 32'(i_q));

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.rd) rdata_q <= mem[raddr];
  end

  // p + q saturating
  logic [32:0] psum;
  logic [31:0] psat;
  assign psum = {1'b0, p_q} + {1'b0, proc_ns_q};
  assign psat = psum[32] ? 32'hFFFF_FFFF : psum[31:0];

  // restoring division step
  logic        bin, ge;
  logic [33:0] rem2, rem_sub;
  assign bin     = (dcnt_q == '0) ? p_q[0] : 1'b0;
  assign rem2    = {rem_q, bin};
  assign ge      = rem2 >= {1'b0, den_q};
  assign rem_sub = rem2 - {1'b0, den_q};

  logic [24:0] k, omk;
  always_comb begin
    priority if (den_q == '0) k = '0;
    else if (quo_q > ONE_Q24) k = ONE_Q24;
    else                      k = quo_q;
  end
  assign omk = ONE_Q24 - k;

  logic [32:0] diff, mag;
  assign diff = {v_q[31], v_q} - {x_q[31], x_q};
  assign mag  = diff[32] ? (33'd0 - diff) : diff;

  logic [32:0] mul_a;
  logic [24:0] mul_b;
  assign mul_a = cmd_i.mulx ? mag : {1'b0, p_q};
  assign mul_b = cmd_i.mulx ? k : omk;

  logic [57:0] rnd;
  logic [31:0] rq;
  assign rnd = prod_q + HALF_Q24;
  assign rq  = rnd[55:24];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ch_q <= in_data_i.channel;
      s_q  <= in_data_i.sample;
    end
    if (cmd_i.wr_last) begin
      x_q <= '0;
      p_q <= init_cov_q;
    end
    if (cmd_i.addq) begin
      v_q    <= rdata_q;
      p_q    <= psat;
      den_q  <= {1'b0, psat} + {1'b0, meas_ns_q};
      rem_q  <= {2'b00, psat[31:1]};
      quo_q  <= '0;
      dcnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q  <= ge ? rem_sub[32:0] : rem2[32:0];
      quo_q  <= {quo_q[23:0], ge};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    if (cmd_i.mulx) begin
      neg_q <= diff[32];
    end
    if (cmd_i.mulx || cmd_i.mulp) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.mulp) begin
      x_q <= x_q + (neg_q ? (32'd0 - rq) : rq);
    end
    if (cmd_i.updp) begin
      p_q <= prod_q[55:24];
    end
    if (cmd_i.load_out) begin
      out_q.estimate <= cmd_i.out_from_x ? x_q : s_q;
      out_q.status   <= cmd_i.out_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
    end else if (cmd_i.capture || cmd_i.wr_last) begin
      i_q <= '0;
    end else if (cmd_i.inc_i) begin
      i_q <= i_q + SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q  <= 5'd16;
      init_cov_q <= 32'd167772160;
      proc_ns_q  <= 32'd1678;
      meas_ns_q  <= 32'd838861;
      min_thr_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIN_LEN:  win_len_q  <= cfg_data_i[4:0];
        CFG_INIT_COV: init_cov_q <= cfg_data_i;
        CFG_PROC_NS:  proc_ns_q  <= cfg_data_i;
        CFG_MEAS_NS:  meas_ns_q  <= cfg_data_i;
        CFG_MIN_THR:  min_thr_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_primed) primed_q[ch_idx] <= 1'b1;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.bypass   = !in_range || (!primed_q[ch_idx] && (s_q < min_thr_q));
  assign sts_o.prime    = !primed_q[ch_idx];
  assign sts_o.i_last   = (i_q == n_m1);
  assign sts_o.div_done = (dcnt_q == DCNT_W'(DIV_STEPS - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/windowed_kalman_smoother.sv -----
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_ready_o   | in_data_i (channel, sample)
// out     | output    | out_valid_o/out_ready_i | out_data_o (estimate, status)
// cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
// Priming fills the window with one window write per cycle.
// Filter: each window step is one memory read, p + q, the radix-2 divider
// steps for k, and multiply and update on the shared 33x25 multiplier.
// Reset clears the primed flags and the controller and loads the config defaults.
// A waiting result is held in the output register; the next item is accepted.
`include "windowed_kalman_smoother_defines.svh"

module windowed_kalman_smoother import wks_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  wks_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wks_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `WKS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")
  `WKS_ASSERT_IMP(a_status_code, out_valid_o, out_data_o.status != 2'd3, "bad status code")
  `WKS_ASSERT_IMP(a_load_when_busy, $rose(out_valid_o), $past(!in_ready_o), "result while idle")

endmodule
